// File: rtl/assert_macros.svh
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that a property holds at every rising clock edge outside reset.
`define ASSERT_PROP(lbl, clk, rst_n, prop) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
		else $error("assertion failed");

// Check that a condition never holds outside reset.
`define ASSERT_NEVER(lbl, clk, rst_n, cond) \
	`ASSERT_PROP(lbl, clk, rst_n, !(cond))

`endif

// File: rtl/pbm_pkg.sv
`timescale 1ns / 1ps

package pbm_pkg;

	localparam int NUM_PROCESSES = 16;
	localparam int IDX_W = (NUM_PROCESSES > 1) ? $clog2(NUM_PROCESSES) : 1;
	localparam int PID_W = 8;
	localparam int TICK_W = 32;

	localparam logic [PID_W:0] PID_LIMIT = (PID_W + 1)'(NUM_PROCESSES);

	localparam logic CMD_SET = 1'b0;
	localparam logic CMD_RECORD = 1'b1;

	localparam logic STATUS_OK = 1'b0;
	localparam logic STATUS_INVALID = 1'b1;

	typedef struct packed {
		logic [TICK_W-1:0] period;
		logic [TICK_W-1:0] capacity;
		logic [TICK_W-1:0] used;
		logic [TICK_W-1:0] pend;
	} budget_t;

	typedef struct packed {
		logic en;
		logic [IDX_W-1:0] idx;
		budget_t data;
	} tbl_wr_t;

endpackage

// File: rtl/pbm_table.sv
`timescale 1ns / 1ps

module pbm_table import pbm_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic [IDX_W-1:0] rd_idx,
	output logic rd_cfg,
	output budget_t rd_data,
	input tbl_wr_t wr
);

	logic [NUM_PROCESSES-1:0] cfg_q;
	budget_t data_q [NUM_PROCESSES];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (wr.en) begin
			cfg_q[wr.idx] <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (wr.en) begin
			data_q[wr.idx] <= wr.data;
		end
	end

	assign rd_cfg = cfg_q[rd_idx];
	assign rd_data = data_q[rd_idx];

endmodule

// File: rtl/periodic_budget_monitor.sv
`timescale 1ns / 1ps

// Periodic execution budget monitor.
// Command channel (cmd_valid/cmd_ready) carries one command per transaction:
// command 0 sets the budget of proc_id (period_len, capacity_ticks,
// start tick), command 1 charges one running tick at the current tick.
// Response channel (rsp_valid/rsp_ready) returns exactly one transaction per
// command, in order: status (0 ok, 1 invalid argument) and violated.
// A command passes from the input register through the table
// read-modify-write into the response register. One command is accepted
// every cycle while the receiver does not stall; the single table update
// per cycle sets that rate.
// When the receiver stalls, the response register holds and the input
// register keeps one more command; cmd_ready then drops until rsp_ready.
// Reset clears both registers and marks every table entry unconfigured;
// the block accepts commands in the first cycle after reset.
module periodic_budget_monitor import pbm_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic cmd_valid,
	output logic cmd_ready,
	input logic command,
	input logic [PID_W-1:0] proc_id,
	input logic [TICK_W-1:0] period_len,
	input logic [TICK_W-1:0] capacity_ticks,
	input logic [TICK_W-1:0] tick,
	output logic rsp_valid,
	input logic rsp_ready,
	output logic status,
	output logic violated
);

	logic valid_s1;
	logic command_s1;
	logic [PID_W-1:0] id_s1;
	logic [TICK_W-1:0] period_s1;
	logic [TICK_W-1:0] capacity_s1;
	logic [TICK_W-1:0] tick_s1;

	logic rsp_valid_q;
	logic status_q;
	logic violated_q;

	logic advance;
	logic id_ok;
	logic args_ok;
	logic rollover;
	logic [IDX_W-1:0] rd_idx;
	logic cur_cfg;
	budget_t cur;
	logic [TICK_W-1:0] base_used;
	logic [TICK_W-1:0] next_used;
	logic [TICK_W-1:0] next_end;
	tbl_wr_t wr;
	logic status_d;
	logic violated_d;

	assign advance = valid_s1 && (!rsp_valid_q || rsp_ready);
	assign cmd_ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (cmd_ready) begin
			valid_s1 <= cmd_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd_valid && cmd_ready) begin
			command_s1 <= command;
			id_s1 <= proc_id;
			period_s1 <= period_len;
			capacity_s1 <= capacity_ticks;
			tick_s1 <= tick;
		end
	end

	assign rd_idx = id_s1[IDX_W-1:0];

	pbm_table u_table (
		.clk(clk),
		.arst_n(arst_n),
		.rd_idx(rd_idx),
		.rd_cfg(cur_cfg),
		.rd_data(cur),
		.wr(wr)
	);

	assign id_ok = {1'b0, id_s1} < PID_LIMIT;
	assign args_ok = (period_s1 != '0) && (capacity_s1 != '0) && (capacity_s1 <= period_s1);
	assign rollover = tick_s1 >= cur.pend;
	assign base_used = rollover ? '0 : cur.used;
	assign next_used = (&base_used) ? base_used : base_used + TICK_W'(1);
	assign next_end = rollover ? cur.pend + cur.period : cur.pend;

	always_comb begin
		wr = '0;
		wr.idx = rd_idx;
		status_d = STATUS_OK;
		violated_d = 1'b0;
		if (!id_ok) begin
			status_d = STATUS_INVALID;
		end else if (command_s1 == CMD_SET) begin
			if (!args_ok) begin
				status_d = STATUS_INVALID;
			end else begin
				wr.en = advance;
				wr.data.period = period_s1;
				wr.data.capacity = capacity_s1;
				wr.data.used = '0;
				wr.data.pend = tick_s1 + period_s1;
			end
		end else if (cur_cfg) begin
			wr.en = advance;
			wr.data.period = cur.period;
			wr.data.capacity = cur.capacity;
			wr.data.used = next_used;
			wr.data.pend = next_end;
			violated_d = next_used > cur.capacity;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (advance) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp_ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			status_q <= status_d;
			violated_q <= violated_d;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign status = status_q;
	assign violated = violated_q;

endmodule

// File: rtl/pbm_checker.sv
`timescale 1ns / 1ps
`include "assert_macros.svh"

module pbm_checker import pbm_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic cmd_valid,
	input logic cmd_ready,
	input logic rsp_valid,
	input logic rsp_ready,
	input logic status,
	input logic violated
);

	`ASSERT_PROP(a_rsp_hold, clk, arst_n, rsp_valid && !rsp_ready |=> rsp_valid && $stable(status) && $stable(violated))
	`ASSERT_NEVER(a_violation_needs_ok, clk, arst_n, rsp_valid && violated && status != STATUS_OK)
	`ASSERT_PROP(a_ready_when_drained, clk, arst_n, !rsp_valid |-> cmd_ready)
	`ASSERT_PROP(a_latency, clk, arst_n, cmd_valid && cmd_ready && !rsp_valid |-> ##2 rsp_valid)

endmodule

bind periodic_budget_monitor pbm_checker u_pbm_checker (
	.clk(clk),
	.arst_n(arst_n),
	.cmd_valid(cmd_valid),
	.cmd_ready(cmd_ready),
	.rsp_valid(rsp_valid),
	.rsp_ready(rsp_ready),
	.status(status),
	.violated(violated)
);

// File: tb/tb_periodic_budget_monitor.sv
`timescale 1ns / 1ps

module tb_periodic_budget_monitor;
	import pbm_pkg::*;

	typedef struct packed {
		logic command;
		logic [PID_W-1:0] pid;
		logic [TICK_W-1:0] period;
		logic [TICK_W-1:0] capacity;
		logic [TICK_W-1:0] at_tick;
	} cmd_t;

	typedef struct packed {
		logic status;
		logic violated;
	} rsp_t;

	typedef struct packed {
		cmd_t c;
		logic typed;
		rsp_t want;
	} dir_row_t;

	logic clk;
	logic arst_n;
	logic cmd_valid;
	logic cmd_ready;
	logic command;
	logic [PID_W-1:0] proc_id;
	logic [TICK_W-1:0] period_len;
	logic [TICK_W-1:0] capacity_ticks;
	logic [TICK_W-1:0] tick;
	logic rsp_valid;
	logic rsp_ready;
	logic status;
	logic violated;

	periodic_budget_monitor dut (.*);

	logic [TICK_W-1:0] bud_period [NUM_PROCESSES];
	logic [TICK_W-1:0] bud_cap [NUM_PROCESSES];
	logic [TICK_W-1:0] bud_used [NUM_PROCESSES];
	logic [TICK_W-1:0] bud_end [NUM_PROCESSES];
	logic bud_live [NUM_PROCESSES];

	rsp_t pending_rsp [$];
	dir_row_t dir_tab [$];
	int mismatch_count = 0;
	int n_sets = 0;
	int n_charges = 0;
	int n_rejected = 0;
	int n_over = 0;
	int n_items = 0;
	bit calm = 1'b0;
	logic [TICK_W-1:0] now_tick = '0;

	initial clk = 1'b0;
	always #6 clk = ~clk;

	initial begin
		#4_000_000;
		$display("FAIL");
		$finish;
	end

	task automatic flag_mismatch(input string what);
		$display("%0t mismatch: %s", $realtime, what);
		mismatch_count++;
	endtask

	function automatic int idle_draw();
		return calm ? 0 : $urandom_range(0, 14);
	endfunction

	function automatic rsp_t budget_outcome(input cmd_t c);
		rsp_t r;
		logic [IDX_W-1:0] slot;
		r.status = STATUS_OK;
		r.violated = 1'b0;
		if (c.pid >= NUM_PROCESSES) begin
			r.status = STATUS_INVALID;
			return r;
		end
		slot = c.pid[IDX_W-1:0];
		if (c.command == CMD_SET) begin
			if (c.period == 0 || c.capacity == 0 || c.capacity > c.period) begin
				r.status = STATUS_INVALID;
				return r;
			end
			bud_period[slot] = c.period;
			bud_cap[slot] = c.capacity;
			bud_used[slot] = '0;
			bud_end[slot] = c.at_tick + c.period;
			bud_live[slot] = 1'b1;
			return r;
		end
		if (!bud_live[slot])
			return r;
		if (c.at_tick >= bud_end[slot]) begin
			bud_used[slot] = '0;
			bud_end[slot] = bud_end[slot] + bud_period[slot];
		end
		if (bud_used[slot] != '1)
			bud_used[slot] = bud_used[slot] + 1'b1;
		r.violated = bud_used[slot] > bud_cap[slot];
		return r;
	endfunction

	function automatic dir_row_t mk_row(input logic cmd, input logic [PID_W-1:0] pid,
			input logic [TICK_W-1:0] per, input logic [TICK_W-1:0] cap,
			input logic [TICK_W-1:0] tk, input logic typed, input logic st,
			input logic vio);
		dir_row_t d;
		d.c.command = cmd;
		d.c.pid = pid;
		d.c.period = per;
		d.c.capacity = cap;
		d.c.at_tick = tk;
		d.typed = typed;
		d.want.status = st;
		d.want.violated = vio;
		return d;
	endfunction

	task automatic push_cmd(input cmd_t c, input logic typed, input rsp_t want);
		int gap;
		rsp_t pred;
		gap = idle_draw();
		if (gap > 0) begin
			cmd_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		cmd_valid <= 1'b1;
		command <= c.command;
		proc_id <= c.pid;
		period_len <= c.period;
		capacity_ticks <= c.capacity;
		tick <= c.at_tick;
		do @(posedge clk); while (!cmd_ready);
		pred = budget_outcome(c);
		pending_rsp.push_back(typed ? want : pred);
		n_items++;
		if (pred.status == STATUS_INVALID)
			n_rejected++;
		else if (c.command == CMD_SET)
			n_sets++;
		else
			n_charges++;
		if (pred.violated)
			n_over++;
	endtask

	task automatic hold_until_drained();
		cmd_valid <= 1'b0;
		while (pending_rsp.size() != 0) @(posedge clk);
	endtask

	always @(posedge clk) begin
		rsp_t want;
		if (arst_n && rsp_valid && rsp_ready) begin
			if (pending_rsp.size() == 0) begin
				flag_mismatch("response with no command outstanding");
			end else begin
				want = pending_rsp.pop_front();
				if (status !== want.status)
					flag_mismatch($sformatf("status got %b want %b", status, want.status));
				if (violated !== want.violated)
					flag_mismatch($sformatf("violated got %b want %b", violated,
						want.violated));
			end
		end
	end

	initial begin
		int stall;
		rsp_ready <= 1'b0;
		wait (arst_n);
		@(posedge clk);
		forever begin
			stall = idle_draw();
			if (stall > 0) begin
				rsp_ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			rsp_ready <= 1'b1;
			do @(posedge clk); while (!rsp_valid);
		end
	end

	initial begin
		cmd_t c;
		int pick;
		int waited;
		arst_n <= 1'b0;
		cmd_valid <= 1'b0;
		command <= CMD_SET;
		proc_id <= '0;
		period_len <= '0;
		capacity_ticks <= '0;
		tick <= '0;
		for (int k = 0; k < NUM_PROCESSES; k++) begin
			bud_period[k] = '0;
			bud_cap[k] = '0;
			bud_used[k] = '0;
			bud_end[k] = '0;
			bud_live[k] = 1'b0;
		end

		dir_tab.push_back(mk_row(CMD_RECORD, 8'd0, 0, 0, 0, 1'b1, STATUS_OK, 1'b0));
		dir_tab.push_back(mk_row(CMD_SET, 8'd255, 10, 5, 0, 1'b1, STATUS_INVALID, 1'b0));
		dir_tab.push_back(mk_row(CMD_RECORD, 8'd16, 0, 0, 0, 1'b1, STATUS_INVALID, 1'b0));
		dir_tab.push_back(mk_row(CMD_SET, 8'd0, 0, 0, 0, 1'b1, STATUS_INVALID, 1'b0));
		dir_tab.push_back(mk_row(CMD_SET, 8'd0, 10, 0, 0, 1'b1, STATUS_INVALID, 1'b0));
		dir_tab.push_back(mk_row(CMD_SET, 8'd0, 10, 11, 0, 1'b1, STATUS_INVALID, 1'b0));
		dir_tab.push_back(mk_row(CMD_SET, 8'd0, 10, 10, 100, 1'b1, STATUS_OK, 1'b0));
		dir_tab.push_back(mk_row(CMD_SET, 8'd15, '1, '1, '1, 1'b1, STATUS_OK, 1'b0));
		dir_tab.push_back(mk_row(CMD_SET, 8'd1, 4, 2, 0, 1'b1, STATUS_OK, 1'b0));
		dir_tab.push_back(mk_row(CMD_RECORD, 8'd1, 0, 0, 0, 1'b0, STATUS_OK, 1'b0));
		dir_tab.push_back(mk_row(CMD_RECORD, 8'd1, 0, 0, 1, 1'b0, STATUS_OK, 1'b0));
		dir_tab.push_back(mk_row(CMD_RECORD, 8'd1, 0, 0, 2, 1'b0, STATUS_OK, 1'b0));
		dir_tab.push_back(mk_row(CMD_RECORD, 8'd1, 0, 0, 4, 1'b0, STATUS_OK, 1'b0));
		dir_tab.push_back(mk_row(CMD_RECORD, 8'd15, 0, 0, 0, 1'b0, STATUS_OK, 1'b0));
		dir_tab.push_back(mk_row(CMD_RECORD, 8'd15, 0, 0, '1, 1'b0, STATUS_OK, 1'b0));
		dir_tab.push_back(mk_row(CMD_SET, 8'd2, 1, 1, '1, 1'b1, STATUS_OK, 1'b0));
		dir_tab.push_back(mk_row(CMD_RECORD, 8'd2, 0, 0, 0, 1'b0, STATUS_OK, 1'b0));
		dir_tab.push_back(mk_row(CMD_RECORD, 8'd2, 0, 0, 0, 1'b0, STATUS_OK, 1'b0));
		dir_tab.push_back(mk_row(CMD_SET, 8'd16, 5, 5, 0, 1'b1, STATUS_INVALID, 1'b0));
		dir_tab.push_back(mk_row(CMD_RECORD, 8'd0, 0, 0, 109, 1'b0, STATUS_OK, 1'b0));
		dir_tab.push_back(mk_row(CMD_RECORD, 8'd0, 0, 0, 110, 1'b0, STATUS_OK, 1'b0));
		dir_tab.push_back(mk_row(CMD_SET, 8'h80, 32'hAAAAAAAA, 32'h55555555, 32'h55555555,
			1'b1, STATUS_INVALID, 1'b0));
		dir_tab.push_back(mk_row(CMD_RECORD, 8'd5, '1, '1, '1, 1'b1, STATUS_OK, 1'b0));

		repeat (4) @(posedge clk);
		arst_n <= 1'b1;

		foreach (dir_tab[r])
			push_cmd(dir_tab[r].c, dir_tab[r].typed, dir_tab[r].want);
		hold_until_drained();

		for (int i = 0; i < 1530; i++) begin
			calm = (i % 250) < 40;
			if (i == 760)
				hold_until_drained();
			pick = $urandom_range(0, 99);
			c.command = CMD_RECORD;
			c.pid = PID_W'($urandom_range(0, NUM_PROCESSES - 1));
			c.period = $urandom;
			c.capacity = $urandom;
			c.at_tick = now_tick;
			if (pick < 10) begin
				c.command = 1'($urandom_range(0, 1));
				c.pid = PID_W'($urandom_range(0, 255));
				c.at_tick = $urandom;
			end else if (pick < 24) begin
				c.command = CMD_SET;
				if ($urandom_range(0, 19) == 0)
					c.pid = PID_W'($urandom_range(NUM_PROCESSES, 255));
				if ($urandom_range(0, 9) == 0)
					c.period = $urandom_range(1, 32'hFFFFFFFF);
				else
					c.period = $urandom_range(1, 30);
				c.capacity = ($urandom_range(0, 3) == 0) ? 1 : $urandom_range(1, c.period);
			end else if (pick < 29) begin
				c.command = CMD_SET;
				case ($urandom_range(0, 2))
					0: c.period = '0;
					1: c.capacity = '0;
					default: begin
						c.period = $urandom_range(1, 32'hFFFFFFFE);
						c.capacity = $urandom_range(c.period + 1, 32'hFFFFFFFF);
					end
				endcase
			end else begin
				now_tick = now_tick + $urandom_range(0, 3);
			end
			if ($urandom_range(0, 199) == 0)
				now_tick = 32'hFFFFFFFF - $urandom_range(0, 60);
			push_cmd(c, 1'b0, rsp_t'(0));
		end
		cmd_valid <= 1'b0;

		waited = 0;
		while (pending_rsp.size() != 0 && waited < 5000) begin
			@(posedge clk);
			waited++;
		end
		repeat (10) @(posedge clk);
		if (pending_rsp.size() != 0)
			flag_mismatch($sformatf("%0d responses never arrived", pending_rsp.size()));

		$display("covered %0d transactions: %0d budget sets, %0d charged ticks, %0d rejected",
			n_items, n_sets, n_charges, n_rejected);
		$display("%0d charges over budget, %0d mismatches", n_over, mismatch_count);
		if (mismatch_count == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule
